// File: rtl/gated_track_table_update_defines.svh
// Assertion macros for the track table
`ifndef GATED_TRACK_TABLE_UPDATE_DEFINES_SVH
`define GATED_TRACK_TABLE_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset
`define GTT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Condition that must never be true outside reset
`define GTT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define GTT_ASSERT(lbl, clk, rst_n, prop)
`define GTT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/gtt_pkg.sv
package gtt_pkg;

  // Table geometry
  localparam int unsigned MAX_TRACKS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_TRACKS);
  localparam int unsigned CNT_W      = 5;

  // Field widths
  localparam int unsigned POS_W  = 16;
  localparam int unsigned CONF_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RAD_W  = 12;
  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned SQ_W   = 2 * POS_W;
  localparam int unsigned DIST_W = SQ_W + 1;
  localparam int unsigned R2_W   = 2 * RAD_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1000);

  // Command codes
  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // One stored track
  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [CONF_W-1:0] conf;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Table write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

// File: rtl/gtt_square.sv
// Shared squaring unit: magnitude of a signed difference, squared
module gtt_square (
  input  logic [gtt_pkg::DIFF_W-1:0] operand_i,
  output logic [gtt_pkg::SQ_W-1:0]   square_o
);
  import gtt_pkg::*;

  logic [DIFF_W-1:0] neg;
  logic [POS_W-1:0]  mag;

  // |a| fits the position width since differences never reach -2^16
  always_comb begin
    neg = DIFF_W'(0) - operand_i;
    mag = operand_i[DIFF_W-1] ? neg[POS_W-1:0] : operand_i[POS_W-1:0];
  end

  assign square_o = SQ_W'(mag) * SQ_W'(mag);

endmodule

// File: rtl/gtt_track_mem.sv
// Track storage, one write port and one registered read port
module gtt_track_mem (
  input  logic                    clk_i,
  input  gtt_pkg::mem_wr_t        wr_i,
  input  logic                    rd_en_i,
  input  logic [gtt_pkg::IDX_W-1:0] rd_addr_i,
  output gtt_pkg::entry_t         rd_data_o
);
  import gtt_pkg::*;

  entry_t mem_q [MAX_TRACKS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/gated_track_table_update.sv
// Observe: start to done covers every one of the N entries in use (max 16).
// Each entry takes four steps through one squarer and one table read port.
// Read: fetches one entry from start to done. One item at a time; busy covers it.
// done_o marks each result for one cycle; the receiver cannot stall.
// Reset empties the table (entry count zero) and sets the match radius to 1000.
module gated_track_table_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  output logic                         done_o,
  input  logic                         cfg_we_i,
  input  logic [gtt_pkg::RAD_W-1:0]    cfg_wdata_i,
  input  logic                         cmd_i,
  input  logic signed [gtt_pkg::POS_W-1:0] obs_x_i,
  input  logic signed [gtt_pkg::POS_W-1:0] obs_y_i,
  input  logic [gtt_pkg::CONF_W-1:0]   obs_confidence_i,
  input  logic [gtt_pkg::TIME_W-1:0]   obs_time_i,
  input  logic [3:0]                   read_index_i,
  output logic [gtt_pkg::CNT_W-1:0]    matched_count_o,
  output logic                         appended_o,
  output logic                         dropped_o,
  output logic [gtt_pkg::CNT_W-1:0]    entries_in_use_o,
  output logic                         entry_valid_o,
  output logic signed [gtt_pkg::POS_W-1:0] entry_x_o,
  output logic signed [gtt_pkg::POS_W-1:0] entry_y_o,
  output logic [gtt_pkg::CONF_W-1:0]   entry_confidence_o,
  output logic [gtt_pkg::TIME_W-1:0]   entry_time_o
);
  import gtt_pkg::*;
  `include "gated_track_table_update_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_RADIUS,
    S_FETCH,
    S_SQX,
    S_SQY,
    S_CMP,
    S_FINISH,
    S_RFETCH,
    S_RDATA
  } state_e;

  state_e            state_q;
  logic [RAD_W-1:0]  radius_q;
  logic [R2_W-1:0]   r2_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  matched_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SQ_W-1:0]   acc_q;
  logic [DIST_W-1:0] dist_q;
  entry_t            obs_q;

  logic              done_q;
  logic [CNT_W-1:0]  res_matched_q;
  logic              res_appended_q;
  logic              res_dropped_q;
  logic [CNT_W-1:0]  res_count_q;
  logic              res_valid_q;
  entry_t            res_entry_q;

  logic [DIFF_W-1:0] sq_in;
  logic [SQ_W-1:0]   sq_out;
  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  entry_t            rd_data;
  mem_wr_t           mem_wr;
  logic              rd_en;
  logic              hit;
  logic              last_entry;
  logic              table_full;

  // Shared squarer and table storage
  gtt_square u_square (
    .operand_i (sq_in),
    .square_o  (sq_out)
  );

  gtt_track_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // Differences against the fetched entry
  always_comb begin
    dx = {obs_q.x[POS_W-1], obs_q.x} - {rd_data.x[POS_W-1], rd_data.x};
    dy = {obs_q.y[POS_W-1], obs_q.y} - {rd_data.y[POS_W-1], rd_data.y};
  end

  // Squarer operand select
  always_comb begin
    case (state_q)
      S_RADIUS: sq_in = {{(DIFF_W-RAD_W){1'b0}}, radius_q};
      S_SQX:    sq_in = dx;
      S_SQY:    sq_in = dy;
      default:  sq_in = '0;
    endcase
  end

  assign hit        = dist_q < {{(DIST_W-R2_W){1'b0}}, r2_q};
  assign last_entry = ({1'b0, idx_q} == (count_q - CNT_W'(1)));
  assign table_full = (count_q >= CNT_W'(MAX_TRACKS));
  assign rd_en      = (state_q == S_FETCH) || (state_q == S_RFETCH);

  // Table writes: overwrite on a hit, append on an unmatched observation if not full
  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.addr = idx_q;
    mem_wr.data = obs_q;
    if (state_q == S_CMP && hit) begin
      mem_wr.en = 1'b1;
    end else if (state_q == S_FINISH && matched_q == '0 && !table_full) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = count_q[IDX_W-1:0];
    end
  end

  // Radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Sequencer and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      matched_q <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            obs_q.x     <= obs_x_i;
            obs_q.y     <= obs_y_i;
            obs_q.conf  <= obs_confidence_i;
            obs_q.stamp <= obs_time_i;
            matched_q   <= '0;
            if (cmd_i == CMD_READ) begin
              idx_q   <= read_index_i[IDX_W-1:0];
              state_q <= S_RFETCH;
            end else begin
              idx_q   <= '0;
              state_q <= S_RADIUS;
            end
          end
        end
        S_RADIUS: begin
          r2_q    <= sq_out[R2_W-1:0];
          state_q <= (count_q == '0) ? S_FINISH : S_FETCH;
        end
        S_FETCH: begin
          state_q <= S_SQX;
        end
        S_SQX: begin
          acc_q   <= sq_out;
          state_q <= S_SQY;
        end
        S_SQY: begin
          dist_q  <= {1'b0, acc_q} + {1'b0, sq_out};
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            matched_q <= matched_q + CNT_W'(1);
          end
          idx_q   <= idx_q + IDX_W'(1);
          state_q <= last_entry ? S_FINISH : S_FETCH;
        end
        S_FINISH: begin
          res_matched_q  <= matched_q;
          res_appended_q <= 1'b0;
          res_dropped_q  <= 1'b0;
          res_count_q    <= count_q;
          res_valid_q    <= 1'b0;
          res_entry_q    <= '0;
          if (matched_q == '0) begin
            if (!table_full) begin
              count_q        <= count_q + CNT_W'(1);
              res_count_q    <= count_q + CNT_W'(1);
              res_appended_q <= 1'b1;
            end else begin
              res_dropped_q <= 1'b1;
            end
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RFETCH: begin
          state_q <= S_RDATA;
        end
        S_RDATA: begin
          res_matched_q  <= '0;
          res_appended_q <= 1'b0;
          res_dropped_q  <= 1'b0;
          res_count_q    <= count_q;
          if ({1'b0, idx_q} < count_q) begin
            res_valid_q <= 1'b1;
            res_entry_q <= rd_data;
          end else begin
            res_valid_q <= 1'b0;
            res_entry_q <= '0;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result ports
  assign busy               = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign matched_count_o    = res_matched_q;
  assign appended_o         = res_appended_q;
  assign dropped_o          = res_dropped_q;
  assign entries_in_use_o   = res_count_q;
  assign entry_valid_o      = res_valid_q;
  assign entry_x_o          = res_entry_q.x;
  assign entry_y_o          = res_entry_q.y;
  assign entry_confidence_o = res_entry_q.conf;
  assign entry_time_o       = res_entry_q.stamp;

  // Checks
  `GTT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy)
  `GTT_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `GTT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(MAX_TRACKS))
  `GTT_ASSERT(a_append_excl, clk_i, rst_ni,
              (done_o && appended_o) |-> (!dropped_o && matched_count_o == '0))

endmodule
